// ----- design/pidaw_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pidaw_pkg
// Shared types, widths and constants of the anti-windup PID regulator.
// ============================================================================
package pidaw_pkg;

   localparam int DRIVE_W    = 32;
   localparam int FIELD_W    = 24;
   localparam int ERR_W      = FIELD_W + 1;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int GAIN_W     = 16;
   localparam int SUM_W      = 40;
   localparam int PPROD_W    = GAIN_W + ERR_W;
   localparam int DERIV_W    = GAIN_W + DIFF_W;
   localparam int MAG_LO_W   = 24;
   localparam int MAG_HI_W   = SUM_W - MAG_LO_W;
   localparam int ACC_W      = SUM_W + GAIN_W;
   localparam int INTEG_W    = 48;
   localparam int PROP_W     = PPROD_W + 1;
   localparam int TOTAL_W    = 50;
   localparam int DIVIDEND_W = ACC_W;
   localparam int DIVISOR_W  = 16;
   localparam int DIV_STEPS  = DIVIDEND_W / 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [DIVISOR_W-1:0] I_SCALE = DIVISOR_W'(1000);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P       = 3'd0,
      REG_GAIN_I       = 3'd1,
      REG_GAIN_D       = 3'd2,
      REG_NORM_DIVISOR = 3'd3,
      REG_DRIVE_OFFSET = 3'd4,
      REG_DRIVE_MIN    = 3'd5,
      REG_DRIVE_MAX    = 3'd6,
      REG_RAMPUP_TICKS = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [GAIN_W-1:0]  norm_divisor;
      logic [DRIVE_W-1:0] drive_offset;
      logic [DRIVE_W-1:0] drive_min;
      logic [DRIVE_W-1:0] drive_max;
      logic [GAIN_W-1:0]  rampup_ticks;
   } cfg_type;

   // One classified tick travelling from front to back.
   typedef struct packed {
      logic [ERR_W-1:0] err;
      logic             skip;
      logic             restart;
   } tick_type;

endpackage

// ----- design/pid_regulator_antiwindup.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pid_regulator_antiwindup
// PID regulator with ramp-up delay and anti-windup on the integral sum.
// ============================================================================
// Ticks enter through a registered front stage and a short queue, so the
// input side keeps taking beats while the core works, until the queue
// fills. A tick with zero error or an invalid measurement is answered
// straight from the idle state with the held drive. A computed tick uses
// one shared restoring divider, two quotient bits per cycle over a 56-bit
// dividend, twice: once for the integral scale of 1000 and once for the
// proportional divisor. Around it the core steps through integration,
// magnitude, the split integral multiply, two adds and the clamp. A new
// tick starts in the core only after the previous result beat has been
// taken.
module pid_regulator_antiwindup #(
   parameter int QUEUE_DEPTH = pidaw_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [pidaw_pkg::FIELD_W-1:0]    req_measured,
   input  logic [pidaw_pkg::FIELD_W-1:0]    req_target,
   input  logic                             req_measured_valid,
   input  logic                             req_restart,
   input  logic                             req_valid,
   output logic                             req_ready,
   output logic [pidaw_pkg::DRIVE_W-1:0]    rsp_drive,
   output logic                             rsp_updated,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             csr_write_enable,
   input  logic [pidaw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pidaw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pidaw_pkg::*;

   cfg_type  cfg_ff;
   logic     push;
   tick_type push_data;
   logic     full;
   logic     pop;
   tick_type pop_data;
   logic     empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff              <= '0;
         cfg_ff.norm_divisor <= GAIN_W'(1);
      end else if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_GAIN_P:       cfg_ff.gain_p       <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_I:       cfg_ff.gain_i       <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:       cfg_ff.gain_d       <= csr_wdata[GAIN_W-1:0];
            REG_NORM_DIVISOR: cfg_ff.norm_divisor <= csr_wdata[GAIN_W-1:0];
            REG_DRIVE_OFFSET: cfg_ff.drive_offset <= csr_wdata[DRIVE_W-1:0];
            REG_DRIVE_MIN:    cfg_ff.drive_min    <= csr_wdata[DRIVE_W-1:0];
            REG_DRIVE_MAX:    cfg_ff.drive_max    <= csr_wdata[DRIVE_W-1:0];
            REG_RAMPUP_TICKS: cfg_ff.rampup_ticks <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pidaw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_measured       (req_measured),
      .req_target         (req_target),
      .req_measured_valid (req_measured_valid),
      .req_restart        (req_restart),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .push               (push),
      .push_data          (push_data),
      .full               (full)
   );

   pidaw_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   pidaw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry       (pop_data),
      .empty       (empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_drive   (rsp_drive),
      .rsp_updated (rsp_updated)
   );

endmodule

// ----- design/pidaw_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pidaw_front
// Input stage: accepts a tick, forms the error and flags ticks to skip.
// ============================================================================
module pidaw_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pidaw_pkg::FIELD_W-1:0] req_measured,
   input  logic [pidaw_pkg::FIELD_W-1:0] req_target,
   input  logic                          req_measured_valid,
   input  logic                          req_restart,
   input  logic                          req_valid,
   output logic                          req_ready,
   output logic                          push,
   output pidaw_pkg::tick_type           push_data,
   input  logic                          full
);
   import pidaw_pkg::*;

   tick_type         held_ff;
   logic             held_valid_ff;
   logic [ERR_W-1:0] err_in;
   tick_type         tick_in;

   assign err_in = {req_target[FIELD_W-1], req_target}
                 - {req_measured[FIELD_W-1], req_measured};

   always_comb begin
      tick_in.err     = err_in;
      tick_in.skip    = (err_in == '0) || !req_measured_valid;
      tick_in.restart = req_restart;
   end

   assign req_ready = !held_valid_ff || !full;
   assign push      = held_valid_ff;
   assign push_data = held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         held_valid_ff <= 1'b1;
      end else if (!full) begin
         held_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         held_ff <= tick_in;
      end
   end

endmodule

// ----- design/pidaw_fifo.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pidaw_fifo
// Short tick queue between the front and back halves.
// ============================================================================
module pidaw_fifo #(
   parameter int DEPTH = pidaw_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pidaw_pkg::tick_type push_data,
   output logic                full,
   input  logic                pop,
   output pidaw_pkg::tick_type pop_data,
   output logic                empty
);
   import pidaw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tick_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ----- design/pidaw_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pidaw_div
// Unsigned restoring divider, two quotient bits per cycle.
// ============================================================================
module pidaw_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pidaw_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [pidaw_pkg::DIVISOR_W-1:0]  divisor,
   output logic                             done,
   output logic [pidaw_pkg::DIVIDEND_W-1:0] quotient
);
   import pidaw_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  den_ff;
   logic [STEP_W-1:0]     cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [DIVISOR_W:0]    r1;
   logic [DIVISOR_W:0]    r2;
   logic [DIVISOR_W:0]    den_ext;
   logic                  ge1;
   logic                  ge2;
   logic [DIVISOR_W-1:0]  rem1;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVIDEND_W-1:0] quo_in;

   always_comb begin
      den_ext = {1'b0, den_ff};
      r1      = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge1     = (r1 >= den_ext);
      rem1    = ge1 ? DIVISOR_W'(r1 - den_ext) : r1[DIVISOR_W-1:0];
      r2      = {rem1, quo_ff[DIVIDEND_W-2]};
      ge2     = (r2 >= den_ext);
      rem_in  = ge2 ? DIVISOR_W'(r2 - den_ext) : r2[DIVISOR_W-1:0];
      quo_in  = {quo_ff[DIVIDEND_W-3:0], ge1, ge2};
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_W'(DIV_STEPS - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ----- design/pidaw_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pidaw_back
// Regulator core: integrator, P/I/D terms, output sum, clamp and result.
// ============================================================================
module pidaw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  pidaw_pkg::cfg_type            cfg,
   input  pidaw_pkg::tick_type           entry,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pidaw_pkg::DRIVE_W-1:0] rsp_drive,
   output logic                          rsp_updated
);
   import pidaw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INTEG, ST_ABS, ST_MUL_LO, ST_MUL_HI, ST_DIV_I, ST_WAIT_I,
      ST_DIV_P, ST_WAIT_P, ST_SUM, ST_ADD, ST_CLAMP
   } state_type;

   state_type                   state_ff;
   logic                        rsp_valid_ff;
   logic [DRIVE_W-1:0]          rsp_drive_ff;
   logic                        rsp_updated_ff;

   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [ERR_W-1:0]     prev_err_ff;
   logic                        prev_valid_ff;
   logic [GAIN_W-1:0]           ramp_ff;
   logic signed [DRIVE_W-1:0]   drive_value_ff;

   logic signed [ERR_W-1:0]     err_ff;
   logic signed [DIFF_W-1:0]    diff_ff;
   logic signed [PPROD_W-1:0]   pprod_ff;
   logic [PPROD_W-1:0]          pmag_ff;
   logic                        sign_p_ff;
   logic [SUM_W-1:0]            mag_ff;
   logic                        sign_i_ff;
   logic signed [DERIV_W-1:0]   deriv_ff;
   logic [ACC_W-1:0]            acc_ff;
   logic signed [INTEG_W-1:0]   integ_ff;
   logic signed [PROP_W-1:0]    prop_ff;
   logic signed [TOTAL_W-1:0]   total_ff;

   logic                        div_start_ff;
   logic [DIVIDEND_W-1:0]       div_num_ff;
   logic [DIVISOR_W-1:0]        div_den_ff;
   logic                        div_done;
   logic [DIVIDEND_W-1:0]       div_quo;

   logic signed [SUM_W:0]       sum_wide_in;
   logic signed [SUM_W-1:0]     sum_sat_in;
   logic signed [DIFF_W-1:0]    diff_in;
   logic signed [PPROD_W-1:0]   pprod_in;
   logic signed [DERIV_W-1:0]   deriv_in;
   logic [SUM_W-1:0]            mag_in;
   logic [PPROD_W-1:0]          pmag_in;
   logic [SUM_W-1:0]            lo_prod_in;
   logic [2*GAIN_W-1:0]         hi_prod_in;
   logic [INTEG_W-1:0]          qi_in;
   logic signed [INTEG_W-1:0]   integ_in;
   logic [PROP_W-1:0]           qp_in;
   logic signed [PROP_W-1:0]    prop_in;
   logic [DIVISOR_W-1:0]        nd_in;
   logic                        in_range_in;
   logic signed [TOTAL_W-1:0]   min_ext;
   logic signed [TOTAL_W-1:0]   max_ext;
   logic signed [TOTAL_W-1:0]   low_in;
   logic signed [DRIVE_W-1:0]   clamp_in;

   always_comb begin
      // saturate the error sum at its 40-bit limits
      sum_wide_in = SUM_W'(sum_ff) + (SUM_W + 1)'(err_ff);
      if (sum_wide_in[SUM_W] != sum_wide_in[SUM_W-1]) begin
         sum_sat_in = sum_wide_in[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                         : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat_in = sum_wide_in[SUM_W-1:0];
      end

      // first tick after a restart has no derivative
      diff_in     = prev_valid_ff ? DIFF_W'(err_ff) - DIFF_W'(prev_err_ff) : '0;
      pprod_in    = $signed(cfg.gain_p) * err_ff;
      deriv_in    = $signed(cfg.gain_d) * diff_ff;
      mag_in      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      pmag_in     = pprod_ff[PPROD_W-1] ? PPROD_W'(-pprod_ff) : PPROD_W'(pprod_ff);
      lo_prod_in  = mag_ff[MAG_LO_W-1:0] * cfg.gain_i;
      hi_prod_in  = mag_ff[SUM_W-1:MAG_LO_W] * cfg.gain_i;

      qi_in       = {1'b0, div_quo[INTEG_W-2:0]};
      integ_in    = sign_i_ff ? -qi_in : qi_in;
      qp_in       = {1'b0, div_quo[PROP_W-2:0]};
      prop_in     = sign_p_ff ? -qp_in : qp_in;
      nd_in       = (cfg.norm_divisor == '0) ? DIVISOR_W'(1) : cfg.norm_divisor;

      in_range_in = (drive_value_ff > $signed(cfg.drive_min))
                 && (drive_value_ff < $signed(cfg.drive_max));

      // raise to min first, then lower to max: max wins when limits cross
      min_ext  = TOTAL_W'($signed(cfg.drive_min));
      max_ext  = TOTAL_W'($signed(cfg.drive_max));
      low_in   = (total_ff < min_ext) ? min_ext : total_ff;
      clamp_in = (low_in > max_ext) ? $signed(cfg.drive_max) : low_in[DRIVE_W-1:0];
   end

   assign pop         = (state_ff == ST_IDLE) && !empty && !rsp_valid_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_updated = rsp_updated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         sum_ff         <= '0;
         prev_err_ff    <= '0;
         prev_valid_ff  <= 1'b0;
         ramp_ff        <= '0;
         drive_value_ff <= '0;
         div_start_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         div_start_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!empty && !rsp_valid_ff) begin
                  if (entry.restart) begin
                     sum_ff        <= '0;
                     prev_valid_ff <= 1'b0;
                     ramp_ff       <= cfg.rampup_ticks;
                  end
                  if (entry.skip) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_drive_ff   <= drive_value_ff;
                     rsp_updated_ff <= 1'b0;
                  end else begin
                     err_ff   <= entry.err;
                     state_ff <= ST_INTEG;
                  end
               end
            end
            ST_INTEG: begin
               diff_ff  <= diff_in;
               pprod_ff <= pprod_in;
               if (cfg.gain_i == '0) begin
                  sum_ff <= '0;
               end else if (ramp_ff != '0) begin
                  ramp_ff <= ramp_ff - 1'b1;
                  sum_ff  <= '0;
               end else if (in_range_in) begin
                  sum_ff <= sum_sat_in;
               end
               state_ff <= ST_ABS;
            end
            ST_ABS: begin
               mag_ff    <= mag_in;
               sign_i_ff <= sum_ff[SUM_W-1];
               pmag_ff   <= pmag_in;
               sign_p_ff <= pprod_ff[PPROD_W-1];
               deriv_ff  <= deriv_in;
               state_ff  <= ST_MUL_LO;
            end
            ST_MUL_LO: begin
               acc_ff   <= ACC_W'(lo_prod_in);
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               acc_ff   <= acc_ff + {hi_prod_in, {MAG_LO_W{1'b0}}};
               state_ff <= ST_DIV_I;
            end
            ST_DIV_I: begin
               div_start_ff <= 1'b1;
               div_num_ff   <= acc_ff;
               div_den_ff   <= I_SCALE;
               state_ff     <= ST_WAIT_I;
            end
            ST_WAIT_I: begin
               if (div_done) begin
                  integ_ff <= integ_in;
                  state_ff <= ST_DIV_P;
               end
            end
            ST_DIV_P: begin
               div_start_ff <= 1'b1;
               div_num_ff   <= DIVIDEND_W'(pmag_ff);
               div_den_ff   <= nd_in;
               state_ff     <= ST_WAIT_P;
            end
            ST_WAIT_P: begin
               if (div_done) begin
                  prop_ff  <= prop_in;
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               total_ff <= TOTAL_W'(prop_ff) + TOTAL_W'(integ_ff);
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               total_ff <= total_ff + TOTAL_W'(deriv_ff)
                         + TOTAL_W'($signed(cfg.drive_offset));
               state_ff <= ST_CLAMP;
            end
            ST_CLAMP: begin
               drive_value_ff <= clamp_in;
               prev_err_ff    <= err_ff;
               prev_valid_ff  <= 1'b1;
               rsp_valid_ff   <= 1'b1;
               rsp_drive_ff   <= clamp_in;
               rsp_updated_ff <= 1'b1;
               state_ff       <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   pidaw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while a tick is in work");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_drive_ff == drive_value_ff))
      else $error("reported drive differs from held drive");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT_I || state_ff == ST_WAIT_P))
      else $error("divider finished with nobody waiting");

   a_clamp_sets_prev: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP) |=> (prev_valid_ff && rsp_updated_ff))
      else $error("computed tick did not record history");

endmodule
